// File: rtl/core/emcm_pkg.sv
// emcm_pkg: shared types, codes and constants of the emg motor command mixer
// depends on: nothing; used by every module of the mixer

package emcm_pkg;

   // field widths
   localparam int unsigned EMG_W   = 12;
   localparam int unsigned DIST_W  = 16;
   localparam int unsigned AGE_W   = 8;
   localparam int unsigned DRIVE_W = 9;
   localparam int unsigned QUOT_W  = 8;
   // numerator 2*n*255 + d stays below 2^21 for 12-bit codes
   localparam int unsigned NUM_W   = EMG_W + 9;
   localparam int unsigned DEN_W   = EMG_W + 1;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // request queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request operation codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_EMG  = 2'd1;
   localparam logic [1:0] OP_DIST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFETY      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRESHNESS   = 3'd6;

   // register reset values
   localparam logic [EMG_W-1:0]  RST_WINDOW_LOW  = 12'd0;
   localparam logic [EMG_W-1:0]  RST_WINDOW_HIGH = 12'd4095;
   localparam logic [DIST_W-1:0] RST_SAFETY      = 16'd100;
   localparam logic [DIST_W-1:0] RST_RECOVERY    = 16'd100;
   localparam logic [AGE_W-1:0]  RST_FRESHNESS   = 8'd4;

   // drive constants
   localparam logic [AGE_W-1:0]          AGE_MAX     = 8'd255;
   localparam logic signed [DRIVE_W-1:0] REVERSE_CMD = -9'sd100;
   localparam logic signed [DRIVE_W-1:0] CENTER_CMD  = 9'sd128;
   localparam logic signed [DRIVE_W-1:0] STOP_CMD    = 9'sd0;
   localparam logic signed [DRIVE_W:0]   DIFF_LIMIT  = 10'sd140;

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_REVERSE = 2'd1,
      MODE_STALE   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_EMG  = 2'd1,
      KIND_DIST = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP_FIRST,
      BK_DIV_FIRST,
      BK_PREP_SECOND,
      BK_DIV_SECOND,
      BK_FINISH
   } back_state_type;

   // classified request as it sits in the queue
   typedef struct packed {
      kind_type           kind;
      logic [EMG_W-1:0]   emg_first;
      logic [EMG_W-1:0]   emg_second;
      logic [DIST_W-1:0]  distance_mm;
   } item_type;

   typedef struct packed {
      logic [EMG_W-1:0]  first_low;
      logic [EMG_W-1:0]  first_high;
      logic [EMG_W-1:0]  second_low;
      logic [EMG_W-1:0]  second_high;
      logic [DIST_W-1:0] safety;
      logic [DIST_W-1:0] recovery;
      logic [AGE_W-1:0]  freshness;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  numerator;
      logic [DEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/core/emg_motor_command_mixer_unit.sv
// emg_motor_command_mixer_unit: top level, register file and wiring of front, back, divider
// depends on: emcm_pkg, emcm_front, emcm_back, emcm_divider

// Turns EMG sample pairs, ultrasonic distances and control ticks into left and
// right drive commands, one result per control tick and none for samples or
// distances. Each request is queued in a two-entry queue and then carried out
// in order: a sample or distance only updates held state, a stale or obstacle
// tick goes straight to the finish state, and a normal steering tick scales
// each EMG channel in turn in the shared serial divider at one quotient bit per
// cycle, unless its window is flat. Requests keep being accepted until the queue
// is full, also while a result waits to be popped. The user must write registers
// through the csr port only while no request is in flight; the block does not enforce it.

module emg_motor_command_mixer_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic [1:0]                              req_operation,
   input  logic [emcm_pkg::EMG_W-1:0]              req_emg_first,
   input  logic [emcm_pkg::EMG_W-1:0]              req_emg_second,
   input  logic [emcm_pkg::DIST_W-1:0]             req_distance_mm,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic signed [emcm_pkg::DRIVE_W-1:0]     rsp_left_drive,
   output logic signed [emcm_pkg::DRIVE_W-1:0]     rsp_right_drive,
   output logic [1:0]                              rsp_drive_mode,
   input  logic                                    csr_write,
   input  logic [emcm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [emcm_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   emcm_pkg::cfg_type      cfg_ff, cfg_in;
   emcm_pkg::item_type     head;
   logic                   head_valid;
   logic                   head_pop;
   emcm_pkg::div_req_type  div_req;
   emcm_pkg::div_rsp_type  div_rsp;

   // register file writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            emcm_pkg::CSR_FIRST_LOW:   cfg_in.first_low   = csr_wdata[emcm_pkg::EMG_W-1:0];
            emcm_pkg::CSR_FIRST_HIGH:  cfg_in.first_high  = csr_wdata[emcm_pkg::EMG_W-1:0];
            emcm_pkg::CSR_SECOND_LOW:  cfg_in.second_low  = csr_wdata[emcm_pkg::EMG_W-1:0];
            emcm_pkg::CSR_SECOND_HIGH: cfg_in.second_high = csr_wdata[emcm_pkg::EMG_W-1:0];
            emcm_pkg::CSR_SAFETY:      cfg_in.safety      = csr_wdata[emcm_pkg::DIST_W-1:0];
            emcm_pkg::CSR_RECOVERY:    cfg_in.recovery    = csr_wdata[emcm_pkg::DIST_W-1:0];
            emcm_pkg::CSR_FRESHNESS:   cfg_in.freshness   = csr_wdata[emcm_pkg::AGE_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_low   <= emcm_pkg::RST_WINDOW_LOW;
         cfg_ff.first_high  <= emcm_pkg::RST_WINDOW_HIGH;
         cfg_ff.second_low  <= emcm_pkg::RST_WINDOW_LOW;
         cfg_ff.second_high <= emcm_pkg::RST_WINDOW_HIGH;
         cfg_ff.safety      <= emcm_pkg::RST_SAFETY;
         cfg_ff.recovery    <= emcm_pkg::RST_RECOVERY;
         cfg_ff.freshness   <= emcm_pkg::RST_FRESHNESS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // intake and queue
   emcm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_emg_first   (req_emg_first),
      .req_emg_second  (req_emg_second),
      .req_distance_mm (req_distance_mm),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop)
   );

   // command sequencer
   emcm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop),
      .div_req         (div_req),
      .div_rsp         (div_rsp),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_drive_mode  (rsp_drive_mode)
   );

   // shared channel scaling divider
   emcm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

// File: rtl/core/emcm_front.sv
// emcm_front: request intake, classification and a short queue to the back end
// depends on: emcm_pkg

module emcm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_operation,
   input  logic [emcm_pkg::EMG_W-1:0]    req_emg_first,
   input  logic [emcm_pkg::EMG_W-1:0]    req_emg_second,
   input  logic [emcm_pkg::DIST_W-1:0]   req_distance_mm,
   output logic                          head_valid,
   output emcm_pkg::item_type            head,
   input  logic                          head_pop
);

   emcm_pkg::item_type                q_mem_ff [emcm_pkg::QUEUE_DEPTH];
   logic [emcm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [emcm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [emcm_pkg::QCNT_W-1:0]       count_ff, count_in;
   emcm_pkg::item_type                item;
   logic                              keep;
   logic                              store;
   logic                              take;

   // classify: the unused operation code is accepted and dropped
   always_comb begin
      item.emg_first   = req_emg_first;
      item.emg_second  = req_emg_second;
      item.distance_mm = req_distance_mm;
      item.kind        = emcm_pkg::KIND_TICK;
      keep             = 1'b1;
      unique case (req_operation)
         emcm_pkg::OP_TICK: item.kind = emcm_pkg::KIND_TICK;
         emcm_pkg::OP_EMG:  item.kind = emcm_pkg::KIND_EMG;
         emcm_pkg::OP_DIST: item.kind = emcm_pkg::KIND_DIST;
         default:           keep = 1'b0;
      endcase
   end

   assign req_full   = (count_ff == emcm_pkg::QCNT_W'(emcm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = q_mem_ff[rd_ptr_ff];
   assign store      = req_push && !req_full && keep;
   assign take       = head_pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (store) begin
         if (wr_ptr_ff == emcm_pkg::QPTR_W'(emcm_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (take) begin
         if (rd_ptr_ff == emcm_pkg::QPTR_W'(emcm_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (store && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !store) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (store) begin
         q_mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: rtl/core/emcm_divider.sv
// emcm_divider: restoring divider, one quotient bit per cycle, 8-bit quotient
// depends on: emcm_pkg; caller guarantees numerator < 256 * divisor

module emcm_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  emcm_pkg::div_req_type div_req,
   output emcm_pkg::div_rsp_type div_rsp
);

   localparam int unsigned CNT_W = $clog2(emcm_pkg::QUOT_W);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [emcm_pkg::NUM_W-1:0]       rem_ff, rem_in;
   logic [emcm_pkg::NUM_W-1:0]       dsh_ff, dsh_in;
   logic [emcm_pkg::QUOT_W-1:0]      quot_ff, quot_in;
   logic                             fits;

   assign fits = (rem_ff >= dsh_ff);

   // one compare and subtract per cycle against the shifted divisor
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(emcm_pkg::QUOT_W - 1);
         rem_in  = div_req.numerator;
         dsh_in  = emcm_pkg::NUM_W'({div_req.divisor, (emcm_pkg::QUOT_W - 1)'(0)});
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[emcm_pkg::QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// File: rtl/core/emcm_back.sv
// emcm_back: held sensor state, obstacle latch, command sequencer and result register
// depends on: emcm_pkg; drives one emcm_divider shared by both channels

module emcm_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  emcm_pkg::cfg_type                    cfg,
   input  logic                                 head_valid,
   input  emcm_pkg::item_type                   head,
   output logic                                 head_pop,
   output emcm_pkg::div_req_type                div_req,
   input  emcm_pkg::div_rsp_type                div_rsp,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [emcm_pkg::DRIVE_W-1:0]  rsp_left_drive,
   output logic signed [emcm_pkg::DRIVE_W-1:0]  rsp_right_drive,
   output logic [1:0]                           rsp_drive_mode
);

   emcm_pkg::back_state_type               state_ff, state_in;
   logic                                   latch_ff, latch_in;
   logic [emcm_pkg::AGE_W-1:0]             age_ff, age_in;
   logic [emcm_pkg::EMG_W-1:0]             first_ff, first_in;
   logic [emcm_pkg::EMG_W-1:0]             second_ff, second_in;
   logic [emcm_pkg::DIST_W-1:0]            dist_ff, dist_in;
   logic signed [emcm_pkg::DRIVE_W-1:0]    left_ff, left_in;
   logic signed [emcm_pkg::DRIVE_W-1:0]    right_ff, right_in;
   emcm_pkg::mode_type                     mode_ff, mode_in;
   logic                                   out_valid_ff, out_valid_in;
   logic signed [emcm_pkg::DRIVE_W-1:0]    out_left_ff, out_left_in;
   logic signed [emcm_pkg::DRIVE_W-1:0]    out_right_ff, out_right_in;
   emcm_pkg::mode_type                     out_mode_ff, out_mode_in;

   logic                                   fresh;
   logic                                   near;
   logic                                   far;
   logic [emcm_pkg::DIST_W:0]              release_dist;
   logic [emcm_pkg::EMG_W-1:0]             clamp_first;
   logic [emcm_pkg::EMG_W-1:0]             clamp_second;
   logic [emcm_pkg::EMG_W-1:0]             sel_code, sel_low, sel_high;
   logic [emcm_pkg::EMG_W-1:0]             span_n, span_d;
   logic                                   flat;
   logic [emcm_pkg::NUM_W-1:0]             numerator;
   logic signed [emcm_pkg::DRIVE_W:0]      diff;
   logic signed [emcm_pkg::DRIVE_W-1:0]    lim_left, lim_right;
   logic signed [emcm_pkg::DRIVE_W-1:0]    scaled;
   logic                                   out_free;
   logic                                   div_start;

   // tick decisions on the held state
   assign fresh        = (age_ff < cfg.freshness);
   assign near         = (dist_ff < cfg.safety);
   assign release_dist = {1'b0, cfg.safety} + {1'b0, cfg.recovery};
   assign far          = ({1'b0, dist_ff} > release_dist);

   // clamp held samples to their windows, low bound tested first
   always_comb begin
      if (first_ff < cfg.first_low) begin
         clamp_first = cfg.first_low;
      end else if (first_ff > cfg.first_high) begin
         clamp_first = cfg.first_high;
      end else begin
         clamp_first = first_ff;
      end
      if (second_ff < cfg.second_low) begin
         clamp_second = cfg.second_low;
      end else if (second_ff > cfg.second_high) begin
         clamp_second = cfg.second_high;
      end else begin
         clamp_second = second_ff;
      end
   end

   // scaling operands of the channel being prepared: (2*n*255 + d) / (2*d)
   always_comb begin
      if (state_ff == emcm_pkg::BK_PREP_FIRST) begin
         sel_code = first_ff;
         sel_low  = cfg.first_low;
         sel_high = cfg.first_high;
      end else begin
         sel_code = second_ff;
         sel_low  = cfg.second_low;
         sel_high = cfg.second_high;
      end
      span_n    = (sel_code >= sel_low) ? sel_code - sel_low : sel_low - sel_code;
      span_d    = (sel_high >= sel_low) ? sel_high - sel_low : sel_low - sel_high;
      flat      = (sel_low == sel_high);
      numerator = {span_n, 9'd0} - emcm_pkg::NUM_W'({span_n, 1'b0})
                  + emcm_pkg::NUM_W'(span_d);
   end

   assign div_req.start     = div_start;
   assign div_req.numerator = numerator;
   assign div_req.divisor   = {span_d, 1'b0};
   assign scaled            = emcm_pkg::DRIVE_W'({1'b0, div_rsp.quotient});

   // wheel difference limit
   always_comb begin
      diff      = {left_ff[emcm_pkg::DRIVE_W-1], left_ff}
                  - {right_ff[emcm_pkg::DRIVE_W-1], right_ff};
      lim_left  = left_ff;
      lim_right = right_ff;
      if (diff > emcm_pkg::DIFF_LIMIT) begin
         lim_left = emcm_pkg::DRIVE_W'({right_ff[emcm_pkg::DRIVE_W-1], right_ff}
                    + emcm_pkg::DIFF_LIMIT);
      end else if (diff < -emcm_pkg::DIFF_LIMIT) begin
         lim_right = emcm_pkg::DRIVE_W'({left_ff[emcm_pkg::DRIVE_W-1], left_ff}
                     + emcm_pkg::DIFF_LIMIT);
      end
   end

   assign out_free = !out_valid_ff || rsp_pop;

   // sequencer: next state and register updates
   always_comb begin
      state_in      = state_ff;
      latch_in      = latch_ff;
      age_in        = age_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      dist_in       = dist_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mode_in       = mode_ff;
      out_left_in   = out_left_ff;
      out_right_in  = out_right_ff;
      out_mode_in   = out_mode_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      head_pop      = 1'b0;
      div_start     = 1'b0;
      unique case (state_ff)
         emcm_pkg::BK_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               unique case (head.kind)
                  emcm_pkg::KIND_EMG: begin
                     first_in  = head.emg_first;
                     second_in = head.emg_second;
                     age_in    = '0;
                  end
                  emcm_pkg::KIND_DIST: begin
                     dist_in = head.distance_mm;
                  end
                  default: begin
                     // control tick: decide from the age as it stands
                     if (age_ff != emcm_pkg::AGE_MAX) begin
                        age_in = age_ff + 1'b1;
                     end
                     if (!fresh) begin
                        left_in  = emcm_pkg::STOP_CMD;
                        right_in = emcm_pkg::STOP_CMD;
                        mode_in  = emcm_pkg::MODE_STALE;
                        state_in = emcm_pkg::BK_FINISH;
                     end else if (latch_ff || near) begin
                        left_in  = emcm_pkg::REVERSE_CMD;
                        right_in = emcm_pkg::REVERSE_CMD;
                        mode_in  = emcm_pkg::MODE_REVERSE;
                        latch_in = !far;
                        state_in = emcm_pkg::BK_FINISH;
                     end else begin
                        first_in  = clamp_first;
                        second_in = clamp_second;
                        mode_in   = emcm_pkg::MODE_NORMAL;
                        state_in  = emcm_pkg::BK_PREP_FIRST;
                     end
                  end
               endcase
            end
         end
         emcm_pkg::BK_PREP_FIRST: begin
            if (flat) begin
               left_in  = emcm_pkg::CENTER_CMD;
               state_in = emcm_pkg::BK_PREP_SECOND;
            end else begin
               div_start = 1'b1;
               state_in  = emcm_pkg::BK_DIV_FIRST;
            end
         end
         emcm_pkg::BK_DIV_FIRST: begin
            if (div_rsp.done) begin
               left_in  = scaled;
               state_in = emcm_pkg::BK_PREP_SECOND;
            end
         end
         emcm_pkg::BK_PREP_SECOND: begin
            if (flat) begin
               right_in = emcm_pkg::CENTER_CMD;
               state_in = emcm_pkg::BK_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = emcm_pkg::BK_DIV_SECOND;
            end
         end
         emcm_pkg::BK_DIV_SECOND: begin
            if (div_rsp.done) begin
               right_in = scaled;
               state_in = emcm_pkg::BK_FINISH;
            end
         end
         emcm_pkg::BK_FINISH: begin
            if (out_free) begin
               out_left_in  = lim_left;
               out_right_in = lim_right;
               out_mode_in  = mode_ff;
               out_valid_in = 1'b1;
               state_in     = emcm_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = emcm_pkg::BK_IDLE;
         end
      endcase
   end

   // control and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= emcm_pkg::BK_IDLE;
         latch_ff     <= 1'b0;
         age_ff       <= emcm_pkg::AGE_MAX;
         first_ff     <= '0;
         second_ff    <= '0;
         dist_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         latch_ff     <= latch_in;
         age_ff       <= age_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         dist_ff      <= dist_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      mode_ff      <= mode_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_mode_ff  <= out_mode_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_left_drive  = out_left_ff;
   assign rsp_right_drive = out_right_ff;
   assign rsp_drive_mode  = out_mode_ff;

endmodule

// File: rtl/core/emcm_checker.sv
// emcm_checker: port-level checks on the mixer's result channel, bound to the top level
// depends on: emcm_pkg, emg_motor_command_mixer_unit

module emcm_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   input  logic                                    req_full,
   input  logic [1:0]                              req_operation,
   input  logic [emcm_pkg::EMG_W-1:0]              req_emg_first,
   input  logic [emcm_pkg::EMG_W-1:0]              req_emg_second,
   input  logic [emcm_pkg::DIST_W-1:0]             req_distance_mm,
   input  logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   input  logic signed [emcm_pkg::DRIVE_W-1:0]     rsp_left_drive,
   input  logic signed [emcm_pkg::DRIVE_W-1:0]     rsp_right_drive,
   input  logic [1:0]                              rsp_drive_mode,
   input  logic                                    csr_write,
   input  logic [emcm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [emcm_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   // nothing pending and queue open right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("mixer not cleared by reset");

   // stale data stops both wheels
   a_stale_stop: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_drive_mode == emcm_pkg::MODE_STALE)
      |-> (rsp_left_drive == emcm_pkg::STOP_CMD && rsp_right_drive == emcm_pkg::STOP_CMD))
      else $error("stale result with nonzero drive");

   // obstacle reverse drives both wheels back
   a_reverse_cmd: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_drive_mode == emcm_pkg::MODE_REVERSE)
      |-> (rsp_left_drive == emcm_pkg::REVERSE_CMD
           && rsp_right_drive == emcm_pkg::REVERSE_CMD))
      else $error("reverse result with wrong drive");

   // normal steering never commands a negative wheel
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_drive_mode == emcm_pkg::MODE_NORMAL)
      |-> (!rsp_left_drive[emcm_pkg::DRIVE_W-1] && !rsp_right_drive[emcm_pkg::DRIVE_W-1]))
      else $error("normal result with negative drive");

   // a waiting result holds until popped
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop)
      |=> (!rsp_empty && $stable(rsp_left_drive) && $stable(rsp_right_drive)
           && $stable(rsp_drive_mode)))
      else $error("waiting result changed before pop");

endmodule

bind emg_motor_command_mixer_unit emcm_checker u_emcm_checker (.*);
